@@ rtl/fcce_pkg.sv @@
// Shared types and constants of the FAT cluster-chain engine.
// Used by fcce_ctrl, fcce_dp and fat_cluster_chain_engine_top; no dependencies.
package fcce_pkg;

  // Command codes
  typedef enum logic [2:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_MARK   = 3'd2,
    CMD_WALK   = 3'd3,
    CMD_ALLOC  = 3'd4,
    CMD_APPEND = 3'd5,
    CMD_FREE   = 3'd6
  } cmd_t;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_NOFREE  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FAT_TYPE  = 2'd0;
  localparam logic [1:0] CFG_LOW_RES   = 2'd1;
  localparam logic [1:0] CFG_HIGH_RES  = 2'd2;
  localparam logic [1:0] CFG_END_MARK  = 2'd3;

  // FAT type codes and entry masks
  localparam logic [1:0]  FAT12 = 2'd0;
  localparam logic [1:0]  FAT16 = 2'd1;
  localparam logic [31:0] MASK12 = 32'h0000_0FFF;
  localparam logic [31:0] MASK16 = 32'h0000_FFFF;
  localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;

  // Reset values of the configuration registers
  localparam logic [31:0] LOW_RES_RST  = 32'h0000_0001;
  localparam logic [31:0] HIGH_RES_RST = 32'h0FFF_FFF0;
  localparam logic [31:0] END_MARK_RST = 32'h0FFF_FFFF;

  // Update of the cursor register
  typedef enum logic [2:0] {
    CUR_HOLD = 3'd0,
    CUR_LOW1 = 3'd1,
    CUR_V    = 3'd2,
    CUR_INC  = 3'd3,
    CUR_WRAP = 3'd4
  } cur_op_t;

  // Update of the result register
  typedef enum logic [1:0] {
    RES_HOLD = 2'd0,
    RES_V    = 2'd1,
    RES_CUR  = 2'd2,
    RES_TAIL = 2'd3
  } res_op_t;

  // Table write data select
  typedef enum logic [1:0] {
    WD_EV   = 2'd0,
    WD_END  = 2'd1,
    WD_ZERO = 2'd2,
    WD_CUR  = 2'd3
  } wd_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       clr_en;
    logic       mem_rd;
    logic       wr_en;
    logic       wr_tail;
    wd_sel_t    wd_sel;
    cur_op_t    cur_op;
    logic       tail_ld;
    logic       cnt_inc;
    res_op_t    res_op;
    logic       st_wr;
    logic [1:0] st_val;
  } dp_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] cmd;
    logic       cur_valid;
    logic       cur_out;
    logic       cur_ge_high;
    logic       cur_eq_tail;
    logic       v_valid;
    logic       v_zero;
    logic       cnt_full;
    logic       cnt_eq_steps;
    logic       clr_last;
  } dp_stat_t;

endpackage

@@ rtl/fcce_dp.sv @@
// Datapath of the FAT cluster-chain engine: table memory, config registers,
// cursor/tail/count registers and compares. Depends on fcce_pkg.
module fcce_dp #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  fcce_pkg::dp_ctrl_t ctl,
  output fcce_pkg::dp_stat_t stat,
  input  logic [2:0]        command,
  input  logic [31:0]       cluster,
  input  logic [31:0]       entry_value,
  input  logic [31:0]       steps,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic [1:0]        status,
  output logic [31:0]       result_cluster
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = AW + 1;

  // Configuration registers
  logic [1:0]  fat_type;
  logic [31:0] low_reserved, high_reserved, end_marker;

  always_ff @(posedge clk) begin
    if (rst) begin
      fat_type      <= fcce_pkg::FAT12;
      low_reserved  <= fcce_pkg::LOW_RES_RST;
      high_reserved <= fcce_pkg::HIGH_RES_RST;
      end_marker    <= fcce_pkg::END_MARK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fcce_pkg::CFG_FAT_TYPE: fat_type      <= cfg_data[1:0];
        fcce_pkg::CFG_LOW_RES:  low_reserved  <= cfg_data;
        fcce_pkg::CFG_HIGH_RES: high_reserved <= cfg_data;
        fcce_pkg::CFG_END_MARK: end_marker    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [31:0] mask;
  always_comb begin
    case (fat_type)
      fcce_pkg::FAT12: mask = fcce_pkg::MASK12;
      fcce_pkg::FAT16: mask = fcce_pkg::MASK16;
      default:         mask = fcce_pkg::MASK32;
    endcase
  end

  // Item registers
  logic [2:0]  cmd_q;
  logic [31:0] ev_q, steps_q, tail, res;
  logic [32:0] cur;
  logic [CW-1:0] cnt;
  logic [1:0]  st;
  logic [AW-1:0] clr_idx;
  logic [31:0] rd_data;
  logic [31:0] v_m;
  logic [32:0] low1, cur_inc, cur_wrap;

  assign v_m      = rd_data & mask;
  assign low1     = {1'b0, low_reserved} + 33'd1;
  assign cur_inc  = cur + 33'd1;
  assign cur_wrap = (cur_inc >= {1'b0, high_reserved}) ? low1 : cur_inc;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= command;
      ev_q    <= entry_value;
      steps_q <= steps;
      cur     <= {1'b0, cluster};
      tail    <= cluster;
      cnt     <= '0;
      st      <= fcce_pkg::ST_OK;
      res     <= (command == fcce_pkg::CMD_WALK) ? cluster : 32'd0;
    end else begin
      case (ctl.cur_op)
        fcce_pkg::CUR_LOW1: cur <= low1;
        fcce_pkg::CUR_V:    cur <= {1'b0, v_m};
        fcce_pkg::CUR_INC:  cur <= cur_inc;
        fcce_pkg::CUR_WRAP: cur <= cur_wrap;
        default: ;
      endcase
      if (ctl.tail_ld) tail <= v_m;
      if (ctl.cnt_inc) cnt <= cnt + CW'(1);
      if (ctl.st_wr) st <= ctl.st_val;
      case (ctl.res_op)
        fcce_pkg::RES_V:    res <= v_m;
        fcce_pkg::RES_CUR:  res <= cur[31:0];
        fcce_pkg::RES_TAIL: res <= tail;
        default: ;
      endcase
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (ctl.clr_en) clr_idx <= clr_idx + AW'(1);
  end

  // Table memory: one write and one registered read per cycle
  logic [31:0]   mem [TABLE_ENTRIES];
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  always_comb begin
    case (ctl.wd_sel)
      fcce_pkg::WD_EV:   wr_data = ev_q & mask;
      fcce_pkg::WD_END:  wr_data = end_marker & mask;
      fcce_pkg::WD_CUR:  wr_data = cur[31:0] & mask;
      default:           wr_data = 32'd0;
    endcase
    if (ctl.clr_en) begin
      wr_addr = clr_idx;
      wr_data = 32'd0;
    end else if (ctl.wr_tail) begin
      wr_addr = tail[AW-1:0];
    end else begin
      wr_addr = cur[AW-1:0];
    end
  end
  assign mem_we = ctl.clr_en | ctl.wr_en;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (ctl.mem_rd) rd_data <= mem[cur[AW-1:0]];
  end

  // Status to the controller
  always_comb begin
    stat.cmd          = cmd_q;
    stat.cur_valid    = (cur > {1'b0, low_reserved}) && (cur < {1'b0, high_reserved});
    stat.cur_out      = cur >= 33'(TABLE_ENTRIES);
    stat.cur_ge_high  = cur >= {1'b0, high_reserved};
    stat.cur_eq_tail  = cur == {1'b0, tail};
    stat.v_valid      = (v_m > low_reserved) && (v_m < high_reserved);
    stat.v_zero       = v_m == 32'd0;
    stat.cnt_full     = cnt == CW'(TABLE_ENTRIES);
    stat.cnt_eq_steps = 32'(cnt) == steps_q;
    stat.clr_last     = clr_idx == AW'(TABLE_ENTRIES - 1);
  end

  assign status         = st;
  assign result_cluster = res;

endmodule

@@ rtl/fcce_ctrl.sv @@
// Controller of the FAT cluster-chain engine: command sequencer state machine.
// Drives fcce_dp through dp_ctrl_t, reads dp_stat_t. Depends on fcce_pkg.
module fcce_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output fcce_pkg::dp_ctrl_t ctl,
  input  fcce_pkg::dp_stat_t stat
);

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_CLEAR     = 16'h0002,
    S_DISP      = 16'h0004,
    S_GET_EV    = 16'h0008,
    S_WALK_CHK  = 16'h0010,
    S_WALK_EV   = 16'h0020,
    S_ALLOC_CHK = 16'h0040,
    S_ALLOC_EV  = 16'h0080,
    S_TAIL_CHK  = 16'h0100,
    S_TAIL_EV   = 16'h0200,
    S_SCAN_CHK  = 16'h0400,
    S_SCAN_EV   = 16'h0800,
    S_WR_TAIL   = 16'h1000,
    S_FREE_CHK  = 16'h2000,
    S_FREE_EV   = 16'h4000,
    S_DONE      = 16'h8000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.wd_sel = fcce_pkg::WD_ZERO;
    ctl.cur_op = fcce_pkg::CUR_HOLD;
    ctl.res_op = fcce_pkg::RES_HOLD;
    ctl.st_val = fcce_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_next = S_DISP;
        end
      end
      S_CLEAR: begin
        ctl.clr_en = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_DISP: begin
        state_next = S_DONE;
        case (stat.cmd)
          fcce_pkg::CMD_GET, fcce_pkg::CMD_SET, fcce_pkg::CMD_MARK: begin
            ctl.st_wr = 1'b1;
            if (!stat.cur_valid) begin
              ctl.st_val = fcce_pkg::ST_INVALID;
            end else if (stat.cur_out) begin
              ctl.st_val = fcce_pkg::ST_OUTSIDE;
            end else if (stat.cmd == fcce_pkg::CMD_GET) begin
              ctl.st_wr  = 1'b0;
              ctl.mem_rd = 1'b1;
              state_next = S_GET_EV;
            end else begin
              ctl.wr_en  = 1'b1;
              ctl.wd_sel = (stat.cmd == fcce_pkg::CMD_SET) ? fcce_pkg::WD_EV
                                                           : fcce_pkg::WD_END;
            end
          end
          fcce_pkg::CMD_WALK, fcce_pkg::CMD_APPEND: begin
            if (!stat.cur_valid) begin
              ctl.st_wr  = 1'b1;
              ctl.st_val = fcce_pkg::ST_INVALID;
            end else begin
              state_next = (stat.cmd == fcce_pkg::CMD_WALK) ? S_WALK_CHK : S_TAIL_CHK;
            end
          end
          fcce_pkg::CMD_ALLOC: begin
            ctl.cur_op = fcce_pkg::CUR_LOW1;
            state_next = S_ALLOC_CHK;
          end
          fcce_pkg::CMD_FREE: state_next = S_FREE_CHK;
          default: begin
            ctl.st_wr  = 1'b1;
            ctl.st_val = fcce_pkg::ST_INVALID;
          end
        endcase
      end
      S_GET_EV: begin
        ctl.res_op = fcce_pkg::RES_V;
        state_next = S_DONE;
      end
      // Walk: follow links until the step count runs out, or the chain ends or leaves the table
      S_WALK_CHK: begin
        if (stat.cnt_eq_steps) begin
          state_next = S_DONE;
        end else if (stat.cnt_full || stat.cur_out) begin
          ctl.st_wr  = 1'b1;
          ctl.st_val = fcce_pkg::ST_OUTSIDE;
          state_next = S_DONE;
        end else begin
          ctl.mem_rd = 1'b1;
          state_next = S_WALK_EV;
        end
      end
      S_WALK_EV: begin
        ctl.cur_op  = fcce_pkg::CUR_V;
        ctl.res_op  = fcce_pkg::RES_V;
        ctl.cnt_inc = 1'b1;
        if (!stat.v_valid) begin
          ctl.st_wr  = 1'b1;
          ctl.st_val = fcce_pkg::ST_INVALID;
          state_next = S_DONE;
        end else begin
          state_next = S_WALK_CHK;
        end
      end
      // Alloc: first free entry from the low end
      S_ALLOC_CHK: begin
        ctl.st_wr = 1'b1;
        if (stat.cur_ge_high) begin
          ctl.st_val = fcce_pkg::ST_NOFREE;
          state_next = S_DONE;
        end else if (stat.cur_out) begin
          ctl.st_val = fcce_pkg::ST_OUTSIDE;
          state_next = S_DONE;
        end else begin
          ctl.st_wr  = 1'b0;
          ctl.mem_rd = 1'b1;
          state_next = S_ALLOC_EV;
        end
      end
      S_ALLOC_EV: begin
        if (stat.v_zero) begin
          ctl.wr_en  = 1'b1;
          ctl.wd_sel = fcce_pkg::WD_END;
          ctl.res_op = fcce_pkg::RES_CUR;
          state_next = S_DONE;
        end else begin
          ctl.cur_op = fcce_pkg::CUR_INC;
          state_next = S_ALLOC_CHK;
        end
      end
      // Append: find the tail, then next-fit search with wrap
      S_TAIL_CHK: begin
        if (stat.cur_out) begin
          ctl.st_wr  = 1'b1;
          ctl.st_val = fcce_pkg::ST_OUTSIDE;
          state_next = S_DONE;
        end else begin
          ctl.mem_rd = 1'b1;
          state_next = S_TAIL_EV;
        end
      end
      S_TAIL_EV: begin
        if (stat.v_valid) begin
          if (stat.cnt_full) begin
            ctl.st_wr  = 1'b1;
            ctl.st_val = fcce_pkg::ST_OUTSIDE;
            state_next = S_DONE;
          end else begin
            ctl.cur_op  = fcce_pkg::CUR_V;
            ctl.tail_ld = 1'b1;
            ctl.cnt_inc = 1'b1;
            state_next  = S_TAIL_CHK;
          end
        end else begin
          ctl.cur_op = fcce_pkg::CUR_WRAP;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        ctl.st_wr = 1'b1;
        if (stat.cur_eq_tail) begin
          ctl.st_val = fcce_pkg::ST_NOFREE;
          state_next = S_DONE;
        end else if (stat.cur_out) begin
          ctl.st_val = fcce_pkg::ST_OUTSIDE;
          state_next = S_DONE;
        end else begin
          ctl.st_wr  = 1'b0;
          ctl.mem_rd = 1'b1;
          state_next = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (stat.v_zero) begin
          ctl.wr_en  = 1'b1;
          ctl.wd_sel = fcce_pkg::WD_END;
          state_next = S_WR_TAIL;
        end else begin
          ctl.cur_op = fcce_pkg::CUR_WRAP;
          state_next = S_SCAN_CHK;
        end
      end
      S_WR_TAIL: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_tail = 1'b1;
        ctl.wd_sel  = fcce_pkg::WD_CUR;
        ctl.res_op  = fcce_pkg::RES_TAIL;
        state_next  = S_DONE;
      end
      // Free: clear each link until an invalid cluster or one outside the table
      S_FREE_CHK: begin
        if (!stat.cur_valid) begin
          state_next = S_DONE;
        end else if (stat.cur_out) begin
          ctl.st_wr  = 1'b1;
          ctl.st_val = fcce_pkg::ST_OUTSIDE;
          state_next = S_DONE;
        end else begin
          ctl.mem_rd = 1'b1;
          state_next = S_FREE_EV;
        end
      end
      S_FREE_EV: begin
        ctl.wr_en  = 1'b1;
        ctl.wd_sel = fcce_pkg::WD_ZERO;
        ctl.cur_op = fcce_pkg::CUR_V;
        state_next = S_FREE_CHK;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Checks
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted command did not make the engine busy");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> (state == S_IDLE))
    else $error("command latched while busy");
  a_clr_excl: assert property (@(posedge clk) disable iff (rst)
    ctl.clr_en |-> !(ctl.wr_en || ctl.mem_rd || ctl.load))
    else $error("table access during clearing pass");

endmodule

@@ rtl/fat_cluster_chain_engine_top.sv @@
// Top level of the FAT cluster-chain engine.
// Instantiates fcce_ctrl and fcce_dp; depends on fcce_pkg.
//
// Usage:
//  - Command channel: drive command/cluster/entry_value/steps with start; the
//    transfer happens at a clock edge with start high and busy low.
//  - Result: done is high for one cycle with status and result_cluster; the
//    receiver cannot stall, so the result is taken in that cycle.
//  - Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//    is always high. Write only while the engine is idle.
//  - Reset: rst loads the config reset values, then a clearing pass zeroes the
//    table, one entry per cycle, with busy high.
//  - Sequencing: a command is taken in idle, dispatched, then runs the check
//    and read states of its kind; the table has one write port and one
//    registered read port, so a check state addresses an entry and the
//    matching read state uses its data. An invalid start goes from dispatch
//    straight to done, and after done the engine returns to idle, where the
//    next command is taken.
module fat_cluster_chain_engine_top #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [31:0] cluster,
  input  logic [31:0] entry_value,
  input  logic [31:0] steps,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] result_cluster,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  fcce_pkg::dp_ctrl_t ctl;
  fcce_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  fcce_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl),
    .stat  (stat)
  );

  fcce_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .command        (command),
    .cluster        (cluster),
    .entry_value    (entry_value),
    .steps          (steps),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .status         (status),
    .result_cluster (result_cluster)
  );

endmodule
